// File: rtl/egcd_pkg.sv
package egcd_pkg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new operand request
        logic init_div;   // start a quotient step: divisor into the shift registers
        logic shift_up;   // alignment: double the shifted divisor and coefficients
        logic sub_step;   // one restoring quotient bit, then halve the shifted terms
        logic swap;       // rotate the remainder and coefficient pairs
        logic capture;    // copy the finished result into the output registers
    } egcd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cur_zero;   // current divisor is zero, Euclid loop is done
        logic align_ok;   // doubled shifted divisor still fits in the remainder
        logic last_bit;   // shifted divisor is back at the unshifted divisor
    } egcd_status_t;

endpackage

// File: rtl/extended_gcd_unit.sv
// Channel   Signals                                   Direction  Accepted when
// operand   operand_valid, operand_stall, operand_a/b in         valid && !stall
// result    result_valid, result_stall, gcd_value,    out        valid && !stall
//           coeff_x, coeff_y
//
// One request at a time. Each Euclid step runs on one shared shift-subtract divider: the
// divisor is doubled while the doubled value still fits in the remainder, then one restoring
// quotient bit is taken per halving back to the divisor, and the remainder pairs rotate.
// The result sits in an output register, so a new request is taken while it waits.
// Reset (rst_n, async, active low) clears only the controller and result valid.
// A stalled result holds; the unit then waits before writing the next one.
module extended_gcd_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         operand_valid,
    output logic                         operand_stall,
    input  logic [DATA_WIDTH-2:0]        operand_a,
    input  logic [DATA_WIDTH-2:0]        operand_b,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [DATA_WIDTH-2:0]        gcd_value,
    output logic signed [DATA_WIDTH-1:0] coeff_x,
    output logic signed [DATA_WIDTH-1:0] coeff_y
);

    egcd_pkg::egcd_cmd_t    cmd;
    egcd_pkg::egcd_status_t status;

    egcd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .cmd           (cmd)
    );

    egcd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .cmd       (cmd),
        .status    (status),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .gcd_value (gcd_value),
        .coeff_x   (coeff_x),
        .coeff_y   (coeff_y)
    );

endmodule

// File: rtl/egcd_datapath.sv
module egcd_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  egcd_pkg::egcd_cmd_t          cmd,
    output egcd_pkg::egcd_status_t       status,
    input  logic [DATA_WIDTH-2:0]        operand_a,
    input  logic [DATA_WIDTH-2:0]        operand_b,
    output logic [DATA_WIDTH-2:0]        gcd_value,
    output logic signed [DATA_WIDTH-1:0] coeff_x,
    output logic signed [DATA_WIDTH-1:0] coeff_y
);

    localparam int OpW   = DATA_WIDTH - 1;
    localparam int CoW   = DATA_WIDTH;
    localparam int WideW = 2 * DATA_WIDTH;

    // Remainder pair and coefficient pairs
    logic [OpW-1:0]   prev_r_reg, cur_r_reg;
    logic [CoW-1:0]   prev_s_reg, cur_s_reg;
    logic [CoW-1:0]   prev_t_reg, cur_t_reg;
    // Shifted divisor and shifted coefficients (exact, sign extended)
    logic [OpW-1:0]   dsh_reg;
    logic [WideW-1:0] ssh_reg, tsh_reg;
    // Output registers
    logic [OpW-1:0]   gcd_reg;
    logic [CoW-1:0]   x_reg, y_reg;

    logic             fits;

    // Status
    assign fits            = (dsh_reg <= prev_r_reg);
    assign status.cur_zero = (cur_r_reg == '0);
    assign status.align_ok = ({dsh_reg, 1'b0} <= {1'b0, prev_r_reg});
    assign status.last_bit = (dsh_reg == cur_r_reg);

    // Euclid registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prev_r_reg <= operand_a;
            cur_r_reg  <= operand_b;
            prev_s_reg <= CoW'(1);
            cur_s_reg  <= '0;
            prev_t_reg <= '0;
            cur_t_reg  <= CoW'(1);
        end
        else if (cmd.sub_step)
        begin
            if (fits)
            begin
                prev_r_reg <= prev_r_reg - dsh_reg;
                prev_s_reg <= prev_s_reg - ssh_reg[CoW-1:0];
                prev_t_reg <= prev_t_reg - tsh_reg[CoW-1:0];
            end
        end
        else if (cmd.swap)
        begin
            prev_r_reg <= cur_r_reg;
            cur_r_reg  <= prev_r_reg;
            prev_s_reg <= cur_s_reg;
            cur_s_reg  <= prev_s_reg;
            prev_t_reg <= cur_t_reg;
            cur_t_reg  <= prev_t_reg;
        end
    end

    // Shift-subtract divider terms
    always_ff @(posedge clk)
    begin
        if (cmd.init_div)
        begin
            dsh_reg <= cur_r_reg;
            ssh_reg <= {{CoW{cur_s_reg[CoW-1]}}, cur_s_reg};
            tsh_reg <= {{CoW{cur_t_reg[CoW-1]}}, cur_t_reg};
        end
        else if (cmd.shift_up)
        begin
            dsh_reg <= {dsh_reg[OpW-2:0], 1'b0};
            ssh_reg <= {ssh_reg[WideW-2:0], 1'b0};
            tsh_reg <= {tsh_reg[WideW-2:0], 1'b0};
        end
        else if (cmd.sub_step)
        begin
            dsh_reg <= {1'b0, dsh_reg[OpW-1:1]};
            ssh_reg <= {ssh_reg[WideW-1], ssh_reg[WideW-1:1]};
            tsh_reg <= {tsh_reg[WideW-1], tsh_reg[WideW-1:1]};
        end
    end

    // Output registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            gcd_reg <= prev_r_reg;
            x_reg   <= prev_s_reg;
            y_reg   <= prev_t_reg;
        end
    end

    assign gcd_value = gcd_reg;
    assign coeff_x   = $signed(x_reg);
    assign coeff_y   = $signed(y_reg);

endmodule

// File: rtl/egcd_ctrl.sv
module egcd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   operand_valid,
    output logic                   operand_stall,
    output logic                   result_valid,
    input  logic                   result_stall,
    input  egcd_pkg::egcd_status_t status,
    output egcd_pkg::egcd_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ALIGN,
        S_SUB,
        S_SWAP,
        S_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   out_free;

    assign out_free = !result_valid_reg || !result_stall;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (operand_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.cur_zero)
                begin
                    state_next = S_HOLD;
                end
                else
                begin
                    cmd.init_div = 1'b1;
                    state_next   = S_ALIGN;
                end
            end
            S_ALIGN:
            begin
                if (status.align_ok)
                    cmd.shift_up = 1'b1;
                else
                    state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.sub_step = 1'b1;
                if (status.last_bit)
                    state_next = S_SWAP;
            end
            S_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = S_CHECK;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid: set on capture, cleared when taken
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.capture)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign operand_stall = (state_reg != S_IDLE);
    assign result_valid  = result_valid_reg;

`ifndef SYNTHESIS
    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !(result_valid_reg && result_stall))
        else $error("egcd: result overwritten while stalled");

    // An accepted request always starts with the divisor check
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (operand_valid && !operand_stall) |=> (state_reg == S_CHECK))
        else $error("egcd: accepted request did not reach check");

    // Last quotient bit leads to the pair rotation
    a_sub_to_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUB && status.last_bit) |=> (state_reg == S_SWAP))
        else $error("egcd: quotient step did not end in swap");

    // A stalled result is held until taken
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> result_valid_reg)
        else $error("egcd: stalled result dropped");
`endif

endmodule
